// File: hdl/b64d_pkg.sv
// b64d_pkg: shared types and constants for the base64 stream decoder
`timescale 1ns / 1ps

package b64d_pkg;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	localparam logic [6:0] SEXTET_NONE = 7'd64;

	typedef struct packed {
		logic [7:0] symbol;
		logic       end_of_string;
	} char_beat_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       final_item;
	} byte_beat_t;

	// one decoded group: up to three bytes, byte 0 goes out first
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      n;
		logic            fin;
	} group_t;

	typedef struct packed {
		logic not_empty;
		logic full;
	} q_status_t;

endpackage

// File: hdl/b64d_front.sv
// b64d_front: character classification, sextet packing and group building
`timescale 1ns / 1ps

module b64d_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                char_valid,
	output logic                char_stall,
	input  b64d_pkg::char_beat_t char_beat,
	input  b64d_pkg::q_status_t  qstat,
	output logic                push,
	output b64d_pkg::group_t     grp
);
	import b64d_pkg::*;

	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		logic [6:0] r;
		begin
			r = SEXTET_NONE;
			if (c >= 8'h41 && c <= 8'h5a) begin
				r = 7'(c - 8'h41);
			end else if (c >= 8'h61 && c <= 8'h7a) begin
				r = 7'(c - 8'h61 + 8'd26);
			end else if (c >= 8'h30 && c <= 8'h39) begin
				r = 7'(c - 8'h30 + 8'd52);
			end else if (c == 8'h2b) begin
				r = 7'd62;
			end else if (c == 8'h2f) begin
				r = 7'd63;
			end
			sextet_of = r;
		end
	endfunction

	logic [17:0] pend_q, pend_n, fl_p;
	logic [1:0]  cnt_q, cnt_n, fl_cnt;
	logic        stopped_q, stopped_n;
	logic [6:0]  v;
	logic        ok, active, acc, dec3, do_flush;
	logic [23:0] w;

	assign char_stall = qstat.full;
	assign acc        = char_valid && !qstat.full;

	always_comb begin
		v         = sextet_of(char_beat.symbol);
		ok        = (v != SEXTET_NONE);
		active    = !stopped_q;
		dec3      = active && ok && (cnt_q == 2'd3);
		w         = {pend_q, v[5:0]};
		pend_n    = pend_q;
		cnt_n     = cnt_q;
		stopped_n = stopped_q;
		do_flush  = 1'b0;
		fl_p      = pend_q;
		fl_cnt    = cnt_q;
		grp       = '0;
		if (active && ok) begin
			if (dec3) begin
				pend_n = '0;
				cnt_n  = '0;
			end else begin
				pend_n = {pend_q[11:0], v[5:0]};
				cnt_n  = cnt_q + 2'd1;
			end
		end
		if (active && !ok) begin
			stopped_n = 1'b1;
			do_flush  = 1'b1;
			pend_n    = '0;
			cnt_n     = '0;
		end else if (active && char_beat.end_of_string) begin
			do_flush = 1'b1;
			fl_p     = pend_n;
			fl_cnt   = cnt_n;
		end
		if (dec3) begin
			grp.bytes[0] = w[23:16];
			grp.bytes[1] = w[15:8];
			grp.bytes[2] = w[7:0];
			grp.n        = 2'd3;
		end else if (do_flush && fl_cnt == 2'd2) begin
			grp.bytes[0] = fl_p[11:4];
			grp.n        = 2'd1;
		end else if (do_flush && fl_cnt == 2'd3) begin
			grp.bytes[0] = fl_p[17:10];
			grp.bytes[1] = fl_p[9:2];
			grp.n        = 2'd2;
		end
		grp.fin = char_beat.end_of_string;
		if (char_beat.end_of_string) begin
			pend_n    = '0;
			cnt_n     = '0;
			stopped_n = 1'b0;
		end
		push = acc && (grp.n != 2'd0 || grp.fin);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q    <= '0;
			cnt_q     <= '0;
			stopped_q <= 1'b0;
		end else if (acc) begin
			pend_q    <= pend_n;
			cnt_q     <= cnt_n;
			stopped_q <= stopped_n;
		end
	end

	a_stop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |-> cnt_q == 2'd0)
		else $error("pending sextets held after stop");

endmodule

// File: hdl/b64d_queue.sv
// b64d_queue: short group queue between front and back
`timescale 1ns / 1ps

module b64d_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  b64d_pkg::group_t    wr,
	input  logic               pop,
	output b64d_pkg::group_t    rd,
	output b64d_pkg::q_status_t status
);
	import b64d_pkg::*;

	group_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wp_q, rp_q;
	logic [QCNT_W-1:0]   cnt_q;

	assign status.full      = (cnt_q == QCNT_W'(QDEPTH));
	assign status.not_empty = (cnt_q != '0);
	assign rd               = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + QPTR_W'(1);
			end
			if (pop) begin
				rp_q <= rp_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !status.full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> status.not_empty)
		else $error("pop from empty queue");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("queue count out of range");

endmodule

// File: hdl/b64d_back.sv
// b64d_back: group serializer driving the byte channel
`timescale 1ns / 1ps

module b64d_back (
	input  logic                clk,
	input  logic                arst_n,
	input  b64d_pkg::q_status_t  qstat,
	input  b64d_pkg::group_t     head,
	output logic                pop,
	output logic                byte_valid,
	input  logic                byte_stall,
	output b64d_pkg::byte_beat_t byte_beat
);
	import b64d_pkg::*;

	group_t     grp_q;
	logic       busy_q;
	logic [1:0] idx_q;
	logic [1:0] last;
	logic       is_last, load;

	assign last       = (grp_q.n == 2'd0) ? 2'd0 : grp_q.n - 2'd1;
	assign is_last    = (idx_q == last);
	assign byte_valid = busy_q;
	assign load       = !busy_q || (!byte_stall && is_last);
	assign pop        = load && qstat.not_empty;

	always_comb begin
		byte_beat            = '0;
		byte_beat.has_byte   = (grp_q.n != 2'd0);
		byte_beat.data_byte  = byte_beat.has_byte ? grp_q.bytes[idx_q] : 8'd0;
		byte_beat.final_item = grp_q.fin && is_last;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			grp_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			busy_q <= qstat.not_empty;
			idx_q  <= '0;
		end else if (!byte_stall) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	a_bare_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && !byte_beat.has_byte |-> byte_beat.final_item)
		else $error("bare beat without end mark");

endmodule

// File: hdl/base64_stream_decoder_top.sv
// base64_stream_decoder_top: base64 stream decoder top level
`timescale 1ns / 1ps

// Takes one base64 character per beat and returns decoded bytes one per beat.
// Character beats are taken at one per cycle; the front decodes each character
// in the cycle it is taken and drops finished groups into a four-entry queue,
// from which the back sends one byte per cycle unless byte_stall is high. The
// input stalls only when that queue is full, i.e. when the byte side is stalled
// or falls behind over several groups. Groups are registered in the queue and
// again in the back. Decoding stops at the first '=' or non-alphabet character,
// flushing the partial group; end_of_string marks the last byte, or gives a
// bare end beat with has_byte low, and clears the state for the next string.
module base64_stream_decoder_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                char_valid,
	output logic                char_stall,
	input  b64d_pkg::char_beat_t char_beat,
	output logic                byte_valid,
	input  logic                byte_stall,
	output b64d_pkg::byte_beat_t byte_beat
);
	import b64d_pkg::*;

	q_status_t qstat;
	group_t    grp_wr, grp_rd;
	logic      push, pop;

	b64d_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_beat  (char_beat),
		.qstat      (qstat),
		.push       (push),
		.grp        (grp_wr)
	);

	b64d_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr     (grp_wr),
		.pop    (pop),
		.rd     (grp_rd),
		.status (qstat)
	);

	b64d_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.qstat      (qstat),
		.head       (grp_rd),
		.pop        (pop),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_beat  (byte_beat)
	);

endmodule
